/* rtl/ntc_pkg.sv */
// ----------------------------------------------------------------------------
// ntc_pkg: shared types and constants of the NTC table interpolator
// Holds the calibration curve, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package ntc_pkg;

   localparam int ADC_BITS     = 12;
   localparam int TEMP_BITS    = 11;
   localparam int TABLE_POINTS = 25;
   localparam int IDX_BITS     = $clog2(TABLE_POINTS);
   localparam int DT_BITS      = TEMP_BITS;            // magnitude of a step in tenths
   localparam int PROD_BITS    = ADC_BITS + DT_BITS;   // numerator of the interpolation
   localparam int CNT_BITS     = $clog2(PROD_BITS);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [ADC_BITS-1:0] ADC_FULL = '1;
   localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(TABLE_POINTS - 1);

   // Register addresses (word index within the APB window).
   localparam logic [CSR_ADDR_BITS-3:0] CSR_PULLUP_IDX = '0;

   // Calibration curve, strictly descending ADC code.
   localparam logic [ADC_BITS-1:0] CURVE_CODE [TABLE_POINTS] = '{
      12'd3740, 12'd3629, 12'd3495, 12'd3337, 12'd3156, 12'd2955, 12'd2738,
      12'd2510, 12'd2278, 12'd2048, 12'd1825, 12'd1614, 12'd1419, 12'd1241,
      12'd1081, 12'd940,  12'd815,  12'd707,  12'd613,  12'd532,  12'd462,
      12'd401,  12'd350,  12'd305,  12'd267
   };

   localparam logic signed [TEMP_BITS-1:0] CURVE_TENTHS [TABLE_POINTS] = '{
      -11'sd200, -11'sd150, -11'sd100, -11'sd50, 11'sd0,   11'sd50,  11'sd100,
      11'sd150,  11'sd200,  11'sd250,  11'sd300, 11'sd350, 11'sd400, 11'sd450,
      11'sd500,  11'sd550,  11'sd600,  11'sd650, 11'sd700, 11'sd750, 11'sd800,
      11'sd850,  11'sd900,  11'sd950,  11'sd1000
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DIFF,
      ST_DEN,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } ntc_state_type;

endpackage

/* rtl/ntc_req_if.sv */
// ----------------------------------------------------------------------------
// ntc_req_if: sample channel
// Valid/ready channel carrying one raw thermistor converter reading a beat.
// ----------------------------------------------------------------------------
interface ntc_req_if;
   logic                         valid;
   logic                         ready;
   logic [ntc_pkg::ADC_BITS-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

/* rtl/ntc_rsp_if.sv */
// ----------------------------------------------------------------------------
// ntc_rsp_if: temperature channel
// Valid/ready channel carrying one temperature result a beat.
// ----------------------------------------------------------------------------
interface ntc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ntc_pkg::TEMP_BITS-1:0] temp_tenths;
   logic                                 in_range;

   modport source (output valid, output temp_tenths, output in_range, input ready);
   modport sink   (input valid, input temp_tenths, input in_range, output ready);
endinterface

/* rtl/ntc_table_interpolator_core.sv */
// ----------------------------------------------------------------------------
// ntc_table_interpolator_core: thermistor sample to temperature
// Scales a converter sample, searches a 25-point curve and interpolates
// linearly within the matching segment, using one shared subtractor.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   req_bus   in         adc_sample (12 bits, unsigned)
//   rsp_bus   out        temp_tenths (11 bits, signed), in_range (1 bit)
//   csr       in/out     APB-style, pullup_to_vcc at byte address 0
//
// A sample is accepted in the idle state, then the segment search visits one
// curve point per cycle (up to 25); an interpolated result then passes the
// offset, span and multiply states, the restoring division and the write of
// the result register, while a sample that clamps to an end of the curve
// goes from the search straight to the result write.
// The segment search and the division share one 13-bit subtractor.
// Reset is synchronous and clears the sequencer, the result valid flag and
// the pull-up register. A waiting result does not block the next sample; only
// when a new result is due while the old one is still untaken does the
// sequencer hold in its final state.
// ----------------------------------------------------------------------------
module ntc_table_interpolator_core (
   input  logic                                clock,
   input  logic                                reset,
   ntc_req_if.sink                             req_bus,
   ntc_rsp_if.source                           rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [ntc_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [ntc_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [ntc_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);

   localparam int AW = ntc_pkg::ADC_BITS;
   localparam int TW = ntc_pkg::TEMP_BITS;
   localparam int IW = ntc_pkg::IDX_BITS;
   localparam int PW = ntc_pkg::PROD_BITS;
   localparam int DW = ntc_pkg::DT_BITS;
   localparam int CW = ntc_pkg::CNT_BITS;
   localparam int SW = AW + 1;   // width of the shared subtractor operands

   // Sequencer and datapath registers.
   ntc_pkg::ntc_state_type state_ff, state_in;
   logic [AW-1:0]         s_ff, s_in;        // scaled sample
   logic [IW-1:0]         k_ff, k_in;        // curve point under test
   logic [AW-1:0]         na_ff, na_in;      // first point code minus sample
   logic [AW-1:0]         d_ff, d_in;        // segment span in codes
   logic [PW-1:0]         num_ff, num_in;    // dividend, shifted out from the top
   logic [PW-1:0]         q_ff, q_in;        // quotient
   logic [AW-1:0]         rem_ff, rem_in;    // partial remainder
   logic [CW-1:0]         cnt_ff, cnt_in;    // division step
   logic signed [TW-1:0]  t0_ff, t0_in;      // temperature at the segment start
   logic                  neg_ff, neg_in;    // segment temperature falls
   logic                  inr_ff, inr_in;    // pending in_range flag

   // Result register and configuration.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [TW-1:0]  rsp_temp_ff, rsp_temp_in;
   logic                  rsp_inr_ff, rsp_inr_in;
   logic                  pullup_ff, pullup_in;

   // Shared subtractor.
   logic [SW-1:0]         sub_a, sub_b;
   logic [SW:0]           sub_res;
   logic                  sub_borrow;

   // Segment helpers.
   logic [IW-1:0]             km1;
   logic signed [TW:0]        seg_dt;
   logic [DW-1:0]             dt_mag;
   logic [SW-1:0]             rem_shift;
   logic signed [TW:0]        t_sum;
   logic                      req_beat;
   logic                      rsp_beat;
   logic                      csr_wr;

   assign req_beat = req_bus.valid && req_bus.ready;
   assign rsp_beat = rsp_bus.valid && rsp_bus.ready;

   assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_borrow = sub_res[SW];

   assign km1    = k_ff - IW'(1);
   assign seg_dt = (TW+1)'(ntc_pkg::CURVE_TENTHS[k_ff]) -
                   (TW+1)'(ntc_pkg::CURVE_TENTHS[km1]);
   assign dt_mag = seg_dt[TW] ? DW'(-seg_dt) : DW'(seg_dt);

   // Next remainder candidate: bring down the top dividend bit.
   assign rem_shift = {rem_ff, num_ff[PW-1]};

   // The quotient never exceeds the step magnitude, so it fits the temperature width.
   assign t_sum = neg_ff ? ((TW+1)'(t0_ff) - (TW+1)'(signed'({1'b0, q_ff[TW-1:0]})))
                         : ((TW+1)'(t0_ff) + (TW+1)'(signed'({1'b0, q_ff[TW-1:0]})));

   // Configuration port: single register, always ready.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite &&
                   (paddr[ntc_pkg::CSR_ADDR_BITS-1:2] == ntc_pkg::CSR_PULLUP_IDX);
   assign pullup_in = csr_wr ? pwdata[0] : pullup_ff;
   assign prdata = (paddr[ntc_pkg::CSR_ADDR_BITS-1:2] == ntc_pkg::CSR_PULLUP_IDX) ?
                   {{(ntc_pkg::CSR_DATA_BITS-1){1'b0}}, pullup_ff} : '0;

   assign req_bus.ready       = (state_ff == ntc_pkg::ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.temp_tenths = rsp_temp_ff;
   assign rsp_bus.in_range    = rsp_inr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ntc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pullup_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pullup_ff    <= pullup_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      k_ff        <= k_in;
      na_ff       <= na_in;
      d_ff        <= d_in;
      num_ff      <= num_in;
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      t0_ff       <= t0_in;
      neg_ff      <= neg_in;
      inr_ff      <= inr_in;
      rsp_temp_ff <= rsp_temp_in;
      rsp_inr_ff  <= rsp_inr_in;
   end

   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      k_in         = k_ff;
      na_in        = na_ff;
      d_in         = d_ff;
      num_in       = num_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      t0_in        = t0_ff;
      neg_in       = neg_ff;
      inr_in       = inr_ff;
      rsp_temp_in  = rsp_temp_ff;
      rsp_inr_in   = rsp_inr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_beat;
      sub_a        = '0;
      sub_b        = '0;

      unique case (state_ff)
         ntc_pkg::ST_IDLE: begin
            if (req_beat) begin
               // With the pull-up to ground the divider reads the other way up.
               s_in     = pullup_ff ? req_bus.adc_sample : ntc_pkg::ADC_FULL - req_bus.adc_sample;
               k_in     = '0;
               state_in = ntc_pkg::ST_SEARCH;
            end
         end

         ntc_pkg::ST_SEARCH: begin
            // The first point whose code is at or below the sample ends the segment.
            sub_a = SW'(s_ff);
            sub_b = SW'(ntc_pkg::CURVE_CODE[k_ff]);
            if (!sub_borrow && (k_ff == '0)) begin
               // At or above the cold end: clamp, in range only on the point itself.
               t0_in    = ntc_pkg::CURVE_TENTHS[0];
               q_in     = '0;
               neg_in   = 1'b0;
               inr_in   = (sub_res == '0);
               state_in = ntc_pkg::ST_DONE;
            end else if (!sub_borrow) begin
               inr_in   = 1'b1;
               state_in = ntc_pkg::ST_DIFF;
            end else if (k_ff == ntc_pkg::IDX_LAST) begin
               // Below the hot end.
               t0_in    = ntc_pkg::CURVE_TENTHS[ntc_pkg::IDX_LAST];
               q_in     = '0;
               neg_in   = 1'b0;
               inr_in   = 1'b0;
               state_in = ntc_pkg::ST_DONE;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end

         ntc_pkg::ST_DIFF: begin
            sub_a    = SW'(ntc_pkg::CURVE_CODE[km1]);
            sub_b    = SW'(s_ff);
            na_in    = sub_res[AW-1:0];
            state_in = ntc_pkg::ST_DEN;
         end

         ntc_pkg::ST_DEN: begin
            sub_a    = SW'(ntc_pkg::CURVE_CODE[km1]);
            sub_b    = SW'(ntc_pkg::CURVE_CODE[k_ff]);
            d_in     = sub_res[AW-1:0];
            state_in = ntc_pkg::ST_MUL;
         end

         ntc_pkg::ST_MUL: begin
            // Both offset and span are magnitudes; the sign comes from the step.
            num_in   = PW'(na_ff) * PW'(dt_mag);
            neg_in   = seg_dt[TW];
            t0_in    = ntc_pkg::CURVE_TENTHS[km1];
            q_in     = '0;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ntc_pkg::ST_DIV;
         end

         ntc_pkg::ST_DIV: begin
            // Restoring division, one quotient bit a cycle; truncates toward zero.
            sub_a  = rem_shift;
            sub_b  = SW'(d_ff);
            num_in = {num_ff[PW-2:0], 1'b0};
            if (!sub_borrow) begin
               rem_in = sub_res[AW-1:0];
               q_in   = {q_ff[PW-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[AW-1:0];
               q_in   = {q_ff[PW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(PW - 1)) begin
               state_in = ntc_pkg::ST_DONE;
            end
         end

         ntc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_temp_in  = t_sum[TW-1:0];
               rsp_inr_in   = inr_ff;
               rsp_valid_in = 1'b1;
               state_in     = ntc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ntc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* dv/tb_ntc_table_interpolator_core.sv */
// ----------------------------------------------------------------------------
// tb_ntc_table_interpolator_core: self-checking bench for the NTC interpolator
// Sends thermistor samples under both pull-up settings, predicts each
// temperature beat with an independent copy of the calibration curve and
// compares every returned beat with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_ntc_table_interpolator_core;

   timeunit 1ns;
   timeprecision 1ps;

   // Own copy of the calibration curve, strictly descending in ADC code.
   localparam int CAL_POINTS = 25;
   localparam int ADC_FULL_SCALE = 4095;
   localparam int CAL_CODE [CAL_POINTS] = '{
      3740, 3629, 3495, 3337, 3156, 2955, 2738, 2510, 2278, 2048, 1825, 1614,
      1419, 1241, 1081, 940, 815, 707, 613, 532, 462, 401, 350, 305, 267
   };
   localparam int CAL_TENTHS [CAL_POINTS] = '{
      -200, -150, -100, -50, 0, 50, 100, 150, 200, 250, 300, 350, 400, 450,
      500, 550, 600, 650, 700, 750, 800, 850, 900, 950, 1000
   };

   // Register map: the pull-up select is the only register; the next word is
   // unmapped and writes to it must have no effect.
   localparam logic [ntc_pkg::CSR_ADDR_BITS-1:0] PULLUP_ADDR =
      {ntc_pkg::CSR_PULLUP_IDX, 2'b00};
   localparam logic [ntc_pkg::CSR_ADDR_BITS-1:0] UNMAPPED_ADDR = 3'd4;

   // Settling time after the last beat before touching the register or
   // ending the run.
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASE_SAMPLES = 80;

   typedef struct packed {
      logic signed [ntc_pkg::TEMP_BITS-1:0] temp_tenths;
      logic                                 in_range;
   } temp_result_type;

   logic                                clock;
   logic                                reset;
   logic                                psel;
   logic                                penable;
   logic                                pwrite;
   logic [ntc_pkg::CSR_ADDR_BITS-1:0]   paddr;
   logic [ntc_pkg::CSR_DATA_BITS-1:0]   pwdata;
   logic [ntc_pkg::CSR_DATA_BITS-1:0]   prdata;
   logic                                pready;

   ntc_req_if req_bus ();
   ntc_rsp_if rsp_bus ();

   // Temperatures predicted for accepted samples, oldest first.
   temp_result_type expected_temps [$];
   logic            pullup_model;
   int unsigned     mismatch_count;
   bit              idling_on;

   ntc_table_interpolator_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run is cut short here if the design stops returning beats.
   initial begin
      #3_000_000;
      $display("ntc_table_interpolator_core test failed");
      $finish;
   end

   // Scales the raw sample according to the pull-up select, then clamps or
   // interpolates along the curve. Division in SystemVerilog truncates toward
   // zero, which is what the hardware is required to do.
   function automatic temp_result_type predict_temp(
      input logic [ntc_pkg::ADC_BITS-1:0] raw,
      input logic pull_to_vcc);
      temp_result_type result;
      int              scaled;
      int              t;
      bit              found;
      scaled = pull_to_vcc ? int'(raw) : ADC_FULL_SCALE - int'(raw);
      result.in_range = (scaled <= CAL_CODE[0]) && (scaled >= CAL_CODE[CAL_POINTS-1]);
      t = CAL_TENTHS[CAL_POINTS-1];
      if (scaled >= CAL_CODE[0]) begin
         t = CAL_TENTHS[0];
      end else if (scaled > CAL_CODE[CAL_POINTS-1]) begin
         found = 1'b0;
         for (int k = 0; k < CAL_POINTS - 1; k++) begin
            if (!found && scaled <= CAL_CODE[k] && scaled >= CAL_CODE[k+1]) begin
               found = 1'b1;
               t = CAL_TENTHS[k] + (scaled - CAL_CODE[k]) * (CAL_TENTHS[k+1] - CAL_TENTHS[k])
                   / (CAL_CODE[k+1] - CAL_CODE[k]);
            end
         end
      end
      result.temp_tenths = t[ntc_pkg::TEMP_BITS-1:0];
      return result;
   endfunction

   // Random sample: uniform half the time, often right around a curve point (after
   // undoing the inversion so the scaled value lands there), sometimes at the
   // very ends of the converter range.
   function automatic logic [ntc_pkg::ADC_BITS-1:0] pick_sample(input logic pull_to_vcc);
      int scaled;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: scaled = $urandom_range(0, ADC_FULL_SCALE);
         5, 6, 7, 8: begin
            scaled = CAL_CODE[$urandom_range(0, CAL_POINTS-1)] + $urandom_range(0, 4) - 2;
         end
         default: scaled = $urandom_range(0, 1) ? ADC_FULL_SCALE : 0;
      endcase
      return pull_to_vcc ? scaled[ntc_pkg::ADC_BITS-1:0]
                         : 12'(ADC_FULL_SCALE - scaled);
   endfunction

   // Presents one sample and holds it until accepted; a random gap may follow.
   task automatic send_sample(input logic [ntc_pkg::ADC_BITS-1:0] raw);
      int unsigned gap;
      req_bus.valid <= 1'b1;
      req_bus.adc_sample <= raw;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_temps.push_back(predict_temp(raw, pullup_model));
      gap = 0;
      if (idling_on && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 9);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every predicted beat has been returned.
   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_temps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [ntc_pkg::CSR_ADDR_BITS-1:0] addr,
                            input logic [ntc_pkg::CSR_DATA_BITS-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (addr == PULLUP_ADDR) pullup_model = data[0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Reads the pull-up register back and checks it against the model.
   task automatic csr_check_pullup();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= PULLUP_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== ntc_pkg::CSR_DATA_BITS'(pullup_model)) begin
         $display("%0t: pullup_to_vcc read expected %0h actual %0h",
                  $time, ntc_pkg::CSR_DATA_BITS'(pullup_model), prdata);
         mismatch_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Writes the pull-up select with random junk in the unused upper bits.
   task automatic set_pullup(input logic value);
      csr_write(PULLUP_ADDR, ($urandom() & ~32'd1) | ntc_pkg::CSR_DATA_BITS'(value));
      csr_check_pullup();
   endtask

   // The receiver stalls in random bursts while idling is enabled.
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Every returned beat is matched against the oldest prediction.
   always @(posedge clock) begin
      temp_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_temps.size() == 0) begin
            $display("%0t: unexpected beat, temp_tenths %0d in_range %0b",
                     $time, rsp_bus.temp_tenths, rsp_bus.in_range);
            mismatch_count++;
         end else begin
            want = expected_temps.pop_front();
            if (rsp_bus.temp_tenths !== want.temp_tenths) begin
               $display("%0t: temp_tenths expected %0d actual %0d",
                        $time, want.temp_tenths, rsp_bus.temp_tenths);
               mismatch_count++;
            end
            if (rsp_bus.in_range !== want.in_range) begin
               $display("%0t: in_range expected %0b actual %0b",
                        $time, want.in_range, rsp_bus.in_range);
               mismatch_count++;
            end
         end
      end
   end

   // The register must come out of reset selecting the inverted sample. The
   // samples land exactly on and just beyond both ends of the curve, and on
   // an inner point.
   task automatic test_reset_setting();
      csr_check_pullup();
      send_sample(12'd355);
      send_sample(12'd354);
      send_sample(12'd0);
      send_sample(12'd3828);
      send_sample(12'd3829);
      send_sample(12'd4095);
      send_sample(12'd2047);
      wait_results_drained();
   endtask

   // Direct use of the sample: both ends with their neighbours, full-scale
   // codes, an inner point and interpolation in negative and positive ranges.
   task automatic test_direct_sample();
      set_pullup(1'b1);
      send_sample(12'd3740);
      send_sample(12'd3741);
      send_sample(12'd4095);
      send_sample(12'd4094);
      send_sample(12'd267);
      send_sample(12'd266);
      send_sample(12'd0);
      send_sample(12'd1);
      send_sample(12'd3156);
      send_sample(12'd3700);
      send_sample(12'd300);
      send_sample(12'd1000);
      send_sample(12'd2730);
      send_sample(12'd268);
      wait_results_drained();
   endtask

   // A write outside the register map must leave the pull-up select alone.
   task automatic test_unmapped_write();
      csr_write(UNMAPPED_ADDR, 32'd0);
      csr_check_pullup();
      send_sample(12'd3739);
      send_sample(12'd2048);
      wait_results_drained();
   endtask

   // Random samples in phases that alternate the pull-up select. Idling is
   // switched on and off in stretches; the final phase runs with none.
   task automatic test_random_sweep();
      for (int phase = 0; phase < 5; phase++) begin
         set_pullup(phase % 2 == 1);
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            if (phase == 4) idling_on = 1'b0;
            else if (n % 20 == 0) idling_on = ($urandom_range(0, 3) != 0);
            // Once, hold the sender back until the block has fully emptied.
            if (phase == 2 && n == PHASE_SAMPLES / 2) wait_results_drained();
            send_sample(pick_sample(pullup_model));
         end
         wait_results_drained();
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.adc_sample <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      pullup_model = 1'b0;
      mismatch_count = 0;
      idling_on = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_setting();
      test_direct_sample();
      test_unmapped_write();
      test_random_sweep();

      if (expected_temps.size() != 0) begin
         $display("%0t: outstanding beats expected 0 actual %0d",
                  $time, expected_temps.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("ntc_table_interpolator_core test passed");
      end else begin
         $display("ntc_table_interpolator_core test failed");
      end
      $finish;
   end

endmodule
